[rtl/sapt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sapt_pkg;

    localparam int TRANSFORM_POINTS = 8192;
    localparam int FRACTION_BITS    = 8;

    localparam int BIN_COUNT = TRANSFORM_POINTS / 2;
    localparam int BIN_W     = $clog2(BIN_COUNT);
    localparam int TP_LOG2   = $clog2(TRANSFORM_POINTS);
    localparam logic [BIN_W-1:0] LAST_BIN  = BIN_W'(BIN_COUNT - 1);
    localparam logic [BIN_W-1:0] FIRST_BIN = BIN_W'(1);

    // field widths
    localparam int IN_W      = 32;
    localparam int MAG_W     = 32;
    localparam int SR_W      = 18;
    localparam int IDX_OUT_W = 12;
    localparam int POS_OUT_W = 20;
    localparam int FQ_W      = 21;
    localparam logic [FQ_W-1:0] FQ_MAX = {FQ_W{1'b1}};

    // square root unit
    localparam int SQ_W   = 2 * IN_W;
    localparam int ROOT_W = IN_W;

    // peak refinement divider: ((|a-c| << F) + |den|) / (2 |den|)
    localparam int NUM_W  = MAG_W + 1 + FRACTION_BITS;
    localparam int DIFF_W = MAG_W + 1;
    localparam int DEN_W  = MAG_W + 3;
    localparam int DD_W   = MAG_W + 2;
    localparam int DIV_W  = DD_W + 1;
    localparam int POS_W  = NUM_W + 1;

    // frequency product, split into two 32-bit multiplies
    localparam int MUL_W      = 32;
    localparam int HI_W       = POS_W - MUL_W;
    localparam int PLO_W      = MUL_W + SR_W;
    localparam int PHI_W      = HI_W + SR_W;
    localparam int TOT_W      = POS_W + SR_W;
    localparam int FQS_W      = TOT_W + 5;
    localparam int FREQ_SHIFT = TP_LOG2 + FRACTION_BITS;

    // stream widths
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 168;

    // configuration
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = SR_W;
    localparam logic [CFG_IDX_W-1:0] REG_AVERAGING_ON = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE  = CFG_IDX_W'(1);
    localparam logic             AVERAGING_RESET   = 1'b1;
    localparam logic [SR_W-1:0]  SAMPLE_RATE_RESET = SR_W'(48000);

endpackage

`default_nettype wire

[rtl/spectrum_average_peak_tracker.sv]
`timescale 1ns / 1ps
`default_nettype none

// Spectrum average and peak tracker.
// s_ channel: one transfer per FFT bin, bins 1 .. N/2-1 of a frame in order.
// m_ channel: one result transfer per input bin; tlast marks the last bin of the frame,
// and only then do the peak fields carry the peak bin, refined position, frequency and
// magnitude (zero otherwise). cfg_ port writes averaging_on (index 0) and
// sample_rate_hz (index 1); write only while the block is idle.
// One bin is worked on at a time: s_tready is high only when the block is idle.
// A result is loaded into the output register once the square root unit, one magnitude
// bit per cycle, has finished; the next bin is taken only after that. The last bin of a
// frame also runs the parabolic refinement (41-bit divider, one quotient bit per cycle)
// unless it is skipped, and then the two partial products of the frequency.
// The per-bin averages live in a single-port RAM, read at the input transfer and written
// back once the magnitude is known. After reset the RAM is not swept: during the first
// frame every stored average reads as zero.
// Reset (aresetn, synchronous) restores both registers, the bin counter and peak state.
// The result sits in an output register; a stalled receiver holds the block at the end
// of the next bin until that register drains.
module spectrum_average_peak_tracker (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // s_tdata: bin_real [31:0], bin_imag [63:32]
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [sapt_pkg::S_TDATA_W-1:0]       s_tdata,
    // m_tdata: bin_index [11:0], raw_magnitude [43:12], avg_magnitude [75:44],
    //          peak_bin [87:76], peak_position [107:88], peak_freq_q4 [128:108],
    //          peak_magnitude [160:129], zero fill [167:161]
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [sapt_pkg::M_TDATA_W-1:0]            m_tdata,
    output logic                                      m_tlast,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [sapt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [sapt_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_RE,
        ST_SQ_IM,
        ST_SUM,
        ST_SQRT,
        ST_UPDATE,
        ST_PREP,
        ST_ARM,
        ST_DIV,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_FREQ,
        ST_DONE
    } state_t;

    localparam int BIN_W = sapt_pkg::BIN_W;
    localparam int MAG_W = sapt_pkg::MAG_W;
    localparam int F     = sapt_pkg::FRACTION_BITS;

    // configuration
    logic                      averaging_reg;
    logic [sapt_pkg::SR_W-1:0] sample_rate_reg;

    // control
    state_t             state_reg;
    logic [BIN_W-1:0]   counter_reg;
    logic               first_pass_reg;
    logic               m_tvalid_reg;

    // peak tracking
    logic [MAG_W-1:0]   best_mag_reg;
    logic [BIN_W-1:0]   best_idx_reg;
    logic [MAG_W-1:0]   prev_mag_reg;
    logic [MAG_W-1:0]   left_reg;
    logic [MAG_W-1:0]   right_reg;
    logic               awaiting_reg;

    // datapath
    logic [sapt_pkg::IN_W-1:0]    re_abs_reg;
    logic [sapt_pkg::IN_W-1:0]    im_abs_reg;
    logic [sapt_pkg::SQ_W-1:0]    sq_re_reg;
    logic [sapt_pkg::SQ_W-1:0]    sq_im_reg;
    logic [MAG_W-1:0]             mag_reg;
    logic [MAG_W-1:0]             rd_reg;
    logic signed [sapt_pkg::DEN_W-1:0]  den_reg;
    logic signed [sapt_pkg::DIFF_W-1:0] diff_reg;
    logic                         lower_reg;
    logic [sapt_pkg::POS_W-1:0]   pos_reg;
    logic [sapt_pkg::PLO_W-1:0]   plo_reg;
    logic [sapt_pkg::PHI_W-1:0]   phi_reg;

    // pending result
    logic [BIN_W-1:0]                  res_idx_reg;
    logic [MAG_W-1:0]                  res_mag_reg;
    logic [MAG_W-1:0]                  res_avg_reg;
    logic                              res_last_reg;
    logic [sapt_pkg::IDX_OUT_W-1:0]    res_pbin_reg;
    logic [sapt_pkg::POS_OUT_W-1:0]    res_pos_reg;
    logic [sapt_pkg::FQ_W-1:0]         res_fq_reg;
    logic [MAG_W-1:0]                  res_pmag_reg;

    logic [sapt_pkg::M_TDATA_W-1:0]    m_tdata_reg;
    logic                              m_tlast_reg;

    logic [MAG_W-1:0] avg_mem [sapt_pkg::BIN_COUNT];

    logic s_xfer;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;

    // output register takes the result when it is empty or draining this cycle
    logic out_load;
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    // ---------------- input magnitudes
    logic [sapt_pkg::IN_W-1:0] in_re;
    logic [sapt_pkg::IN_W-1:0] in_im;
    logic [sapt_pkg::IN_W-1:0] re_abs;
    logic [sapt_pkg::IN_W-1:0] im_abs;

    assign in_re  = s_tdata[sapt_pkg::IN_W-1:0];
    assign in_im  = s_tdata[2*sapt_pkg::IN_W-1:sapt_pkg::IN_W];
    assign re_abs = in_re[sapt_pkg::IN_W-1] ? ~in_re + 1'b1 : in_re;
    assign im_abs = in_im[sapt_pkg::IN_W-1] ? ~in_im + 1'b1 : in_im;

    // ---------------- shared multiplier
    logic [sapt_pkg::MUL_W-1:0]   mul_a;
    logic [sapt_pkg::MUL_W-1:0]   mul_b;
    logic [2*sapt_pkg::MUL_W-1:0] mul_p;

    always_comb begin
        case (state_reg)
            ST_SQ_RE: begin
                mul_a = re_abs_reg;
                mul_b = re_abs_reg;
            end
            ST_SQ_IM: begin
                mul_a = im_abs_reg;
                mul_b = im_abs_reg;
            end
            ST_MUL_LO: begin
                mul_a = pos_reg[sapt_pkg::MUL_W-1:0];
                mul_b = sapt_pkg::MUL_W'(sample_rate_reg);
            end
            ST_MUL_HI: begin
                mul_a = sapt_pkg::MUL_W'(pos_reg[sapt_pkg::POS_W-1:sapt_pkg::MUL_W]);
                mul_b = sapt_pkg::MUL_W'(sample_rate_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = (2*sapt_pkg::MUL_W)'(mul_a) * (2*sapt_pkg::MUL_W)'(mul_b);

    // ---------------- square root
    logic                        sqrt_done;
    logic [sapt_pkg::ROOT_W-1:0] sqrt_root;

    sapt_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_SUM),
        .radicand (sq_re_reg + sq_im_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // ---------------- average update
    logic [MAG_W-1:0]        avg_old;
    logic signed [MAG_W:0]   avg_diff;
    logic signed [MAG_W:0]   avg_step;
    logic signed [MAG_W:0]   avg_sum;
    logic [MAG_W-1:0]        store_val;
    logic                    is_last;
    logic                    new_best;

    assign avg_old   = first_pass_reg ? '0 : rd_reg;
    assign avg_diff  = $signed({1'b0, mag_reg}) - $signed({1'b0, avg_old});
    assign avg_step  = avg_diff >>> 2;
    assign avg_sum   = $signed({1'b0, avg_old}) + avg_step;
    assign store_val = averaging_reg ? avg_sum[MAG_W-1:0] : mag_reg;
    assign is_last   = (counter_reg == sapt_pkg::LAST_BIN);
    assign new_best  = store_val > best_mag_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_UPDATE) begin
            avg_mem[counter_reg] <= store_val;
        end
        if (s_xfer) begin
            rd_reg <= avg_mem[counter_reg];
        end
    end

    // ---------------- parabolic refinement
    logic [sapt_pkg::DD_W-1:0]   dd;
    logic [sapt_pkg::DIFF_W-1:0] ad;
    logic                        refine;
    logic [sapt_pkg::NUM_W-1:0]  div_num;
    logic [sapt_pkg::DIV_W-1:0]  div_den;
    logic                        div_done;
    logic [sapt_pkg::NUM_W-1:0]  div_quo;
    logic [sapt_pkg::POS_W-1:0]  pos_base;
    logic [sapt_pkg::POS_W-1:0]  pos_off;

    assign dd = den_reg[sapt_pkg::DEN_W-1] ? sapt_pkg::DD_W'(-den_reg)
                                           : sapt_pkg::DD_W'(den_reg);
    assign ad = diff_reg[sapt_pkg::DIFF_W-1] ? sapt_pkg::DIFF_W'(-diff_reg)
                                             : sapt_pkg::DIFF_W'(diff_reg);
    // peak at the edges of the band or a flat top keeps the plain bin position
    assign refine  = (best_idx_reg > sapt_pkg::FIRST_BIN) &&
                     (best_idx_reg != sapt_pkg::LAST_BIN) && (dd != '0);
    assign div_num = (sapt_pkg::NUM_W'(ad[MAG_W-1:0]) << F) + sapt_pkg::NUM_W'(dd);
    assign div_den = {dd, 1'b0};

    assign pos_base = sapt_pkg::POS_W'(best_idx_reg) << F;
    assign pos_off  = sapt_pkg::POS_W'(div_quo);

    sapt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    ((state_reg == ST_ARM) && refine),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    // ---------------- frequency: (pos * rate * 16 + half) >> shift, saturated
    logic [sapt_pkg::TOT_W-1:0] freq_prod;
    logic [sapt_pkg::FQS_W-1:0] freq_scaled;
    logic [sapt_pkg::FQS_W-1:0] freq_full;
    logic [sapt_pkg::FQ_W-1:0]  freq_sat;

    assign freq_prod   = sapt_pkg::TOT_W'(plo_reg) +
                         (sapt_pkg::TOT_W'(phi_reg) << sapt_pkg::MUL_W);
    assign freq_scaled = {freq_prod, 4'b0000} +
                         (sapt_pkg::FQS_W'(1) << (sapt_pkg::FREQ_SHIFT - 1));
    assign freq_full   = freq_scaled >> sapt_pkg::FREQ_SHIFT;
    assign freq_sat    = (freq_full > sapt_pkg::FQS_W'(sapt_pkg::FQ_MAX))
                         ? sapt_pkg::FQ_MAX : freq_full[sapt_pkg::FQ_W-1:0];

    // ---------------- configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            averaging_reg   <= sapt_pkg::AVERAGING_RESET;
            sample_rate_reg <= sapt_pkg::SAMPLE_RATE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                sapt_pkg::REG_AVERAGING_ON: averaging_reg   <= cfg_wdata[0];
                sapt_pkg::REG_SAMPLE_RATE:  sample_rate_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            counter_reg    <= sapt_pkg::FIRST_BIN;
            first_pass_reg <= 1'b1;
            m_tvalid_reg   <= 1'b0;
            best_mag_reg   <= '0;
            best_idx_reg   <= '0;
            prev_mag_reg   <= '0;
            left_reg       <= '0;
            right_reg      <= '0;
            awaiting_reg   <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_xfer) begin
                        re_abs_reg <= re_abs;
                        im_abs_reg <= im_abs;
                        state_reg  <= ST_SQ_RE;
                    end
                end
                ST_SQ_RE: begin
                    sq_re_reg <= mul_p;
                    state_reg <= ST_SQ_IM;
                end
                ST_SQ_IM: begin
                    sq_im_reg <= mul_p;
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    state_reg <= ST_SQRT;
                end
                ST_SQRT: begin
                    if (sqrt_done) begin
                        mag_reg   <= sqrt_root;
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    if (awaiting_reg) begin
                        right_reg <= store_val;
                    end
                    awaiting_reg <= new_best;
                    if (new_best) begin
                        best_mag_reg <= store_val;
                        best_idx_reg <= counter_reg;
                        left_reg     <= prev_mag_reg;
                    end
                    prev_mag_reg <= store_val;
                    res_idx_reg  <= counter_reg;
                    res_mag_reg  <= mag_reg;
                    res_avg_reg  <= store_val;
                    res_last_reg <= is_last;
                    res_pbin_reg <= '0;
                    res_pos_reg  <= '0;
                    res_fq_reg   <= '0;
                    res_pmag_reg <= '0;
                    if (is_last) begin
                        counter_reg    <= sapt_pkg::FIRST_BIN;
                        first_pass_reg <= 1'b0;
                        state_reg      <= ST_PREP;
                    end else begin
                        counter_reg <= counter_reg + 1'b1;
                        state_reg   <= ST_DONE;
                    end
                end
                ST_PREP: begin
                    den_reg   <= $signed({2'b00, best_mag_reg, 1'b0}) -
                                 $signed({3'b000, left_reg}) -
                                 $signed({3'b000, right_reg});
                    diff_reg  <= $signed({1'b0, left_reg}) - $signed({1'b0, right_reg});
                    state_reg <= ST_ARM;
                end
                ST_ARM: begin
                    // offset moves toward the lower bin when a-c and the curvature agree
                    lower_reg <= ((diff_reg > 0) == (den_reg > 0));
                    if (refine) begin
                        state_reg <= ST_DIV;
                    end else begin
                        pos_reg   <= pos_base;
                        state_reg <= ST_MUL_LO;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        if (lower_reg) begin
                            pos_reg <= (pos_off > pos_base) ? '0 : pos_base - pos_off;
                        end else begin
                            pos_reg <= pos_base + pos_off;
                        end
                        state_reg <= ST_MUL_LO;
                    end
                end
                ST_MUL_LO: begin
                    plo_reg   <= mul_p[sapt_pkg::PLO_W-1:0];
                    state_reg <= ST_MUL_HI;
                end
                ST_MUL_HI: begin
                    phi_reg   <= mul_p[sapt_pkg::PHI_W-1:0];
                    state_reg <= ST_FREQ;
                end
                ST_FREQ: begin
                    res_pbin_reg <= sapt_pkg::IDX_OUT_W'(best_idx_reg);
                    res_pos_reg  <= pos_reg[sapt_pkg::POS_OUT_W-1:0];
                    res_fq_reg   <= freq_sat;
                    res_pmag_reg <= best_mag_reg;
                    best_mag_reg <= '0;
                    best_idx_reg <= '0;
                    prev_mag_reg <= '0;
                    left_reg     <= '0;
                    right_reg    <= '0;
                    awaiting_reg <= 1'b0;
                    state_reg    <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_load) begin
                        m_tlast_reg  <= res_last_reg;
                        m_tdata_reg  <= sapt_pkg::M_TDATA_W'({
                            res_pmag_reg, res_fq_reg, res_pos_reg, res_pbin_reg,
                            res_avg_reg, res_mag_reg,
                            sapt_pkg::IDX_OUT_W'(res_idx_reg)});
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    a_counter_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        counter_reg != '0)
        else $error("bin counter reached zero");

    a_sqrt_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_done |-> state_reg == ST_SQRT)
        else $error("square root finished outside its wait state");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside its wait state");

    a_peak_zero_mid_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tlast_reg) |-> (m_tdata_reg[sapt_pkg::M_TDATA_W-1:76] == '0))
        else $error("peak fields set on a bin that is not the last");
`endif

endmodule

`default_nettype wire

[rtl/sapt_isqrt.sv]
`timescale 1ns / 1ps
`default_nettype none

// Integer square root, one result bit per cycle, floor(sqrt(radicand)).
module sapt_isqrt (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [sapt_pkg::SQ_W-1:0]   radicand,
    output logic                             done,
    output logic [sapt_pkg::ROOT_W-1:0]      root
);

    localparam int REM_W = sapt_pkg::ROOT_W + 3;
    localparam int CNT_W = $clog2(sapt_pkg::ROOT_W);

    logic [sapt_pkg::SQ_W-1:0]   rad_reg;
    logic [REM_W-1:0]            rem_reg;
    logic [sapt_pkg::ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;

    logic [REM_W-1:0] rem_shift;
    logic [REM_W-1:0] trial;
    logic             fits;

    assign rem_shift = {rem_reg[REM_W-3:0], rad_reg[sapt_pkg::SQ_W-1 -: 2]};
    assign trial     = REM_W'({root_reg, 2'b01});
    assign fits      = rem_shift >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= CNT_W'(sapt_pkg::ROOT_W - 1);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rad_reg  <= rad_reg << 2;
                rem_reg  <= fits ? rem_shift - trial : rem_shift;
                root_reg <= {root_reg[sapt_pkg::ROOT_W-2:0], fits};
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

[rtl/sapt_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle.
module sapt_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [sapt_pkg::NUM_W-1:0]  dividend,
    input  wire logic [sapt_pkg::DIV_W-1:0]  divisor,
    output logic                             done,
    output logic [sapt_pkg::NUM_W-1:0]       quotient
);

    localparam int CNT_W = $clog2(sapt_pkg::NUM_W);

    // dividend shifts out the top while quotient bits shift in at the bottom
    logic [sapt_pkg::NUM_W-1:0] num_reg;
    logic [sapt_pkg::DIV_W-1:0] den_reg;
    logic [sapt_pkg::DIV_W-1:0] rem_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [sapt_pkg::DIV_W:0] rem_shift;
    logic [sapt_pkg::DIV_W:0] rem_sub;
    logic                     fits;

    assign rem_shift = {rem_reg, num_reg[sapt_pkg::NUM_W-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};
    assign rem_sub   = rem_shift - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                num_reg  <= dividend;
                den_reg  <= divisor;
                rem_reg  <= '0;
                cnt_reg  <= CNT_W'(sapt_pkg::NUM_W - 1);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= fits ? rem_sub[sapt_pkg::DIV_W-1:0]
                                : rem_shift[sapt_pkg::DIV_W-1:0];
                num_reg <= {num_reg[sapt_pkg::NUM_W-2:0], fits};
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import sapt_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 6_000_000;
    localparam int          LONG_HOLD    = 400;
    localparam int          DRAIN_CYCLES = 120;

    typedef enum {
        FRAME_EXTREMES,
        FRAME_BLEND,
        FRAME_TAIL_PEAK,
        FRAME_SILENT,
        FRAME_TIE
    } frame_kind_t;

    class spectrum_scoreboard;
        localparam int RAW_LSB  = IDX_OUT_W;
        localparam int AVG_LSB  = RAW_LSB + MAG_W;
        localparam int PKB_LSB  = AVG_LSB + MAG_W;
        localparam int POS_LSB  = PKB_LSB + IDX_OUT_W;
        localparam int FQ_LSB   = POS_LSB + POS_OUT_W;
        localparam int PKM_LSB  = FQ_LSB + FQ_W;
        localparam int FILL_LSB = PKM_LSB + MAG_W;

        typedef struct {
            logic [IDX_OUT_W-1:0] bin_index;
            logic [MAG_W-1:0]     raw_magnitude;
            logic [MAG_W-1:0]     avg_magnitude;
            logic                 frame_done;
            logic [IDX_OUT_W-1:0] peak_bin;
            logic [POS_OUT_W-1:0] peak_position;
            logic [FQ_W-1:0]      peak_freq_q4;
            logic [MAG_W-1:0]     peak_magnitude;
        } bin_result_t;

        bit                averaging;
        logic [SR_W-1:0]   sample_rate;
        logic [MAG_W-1:0]  avg_mem [BIN_COUNT];
        int unsigned       next_bin;
        int unsigned       best_index;
        logic [MAG_W-1:0]  best_mag;
        logic [MAG_W-1:0]  prev_mag;
        logic [MAG_W-1:0]  left_mag;
        logic [MAG_W-1:0]  right_mag;
        bit                want_right;
        bin_result_t       pending [$];
        int                errors;
        int                checked;

        function new();
            averaging   = AVERAGING_RESET;
            sample_rate = SAMPLE_RATE_RESET;
            foreach (avg_mem[i]) avg_mem[i] = '0;
            errors  = 0;
            checked = 0;
            clear_track();
        endfunction

        function void clear_track();
            next_bin   = 1;
            best_index = 0;
            best_mag   = '0;
            prev_mag   = '0;
            left_mag   = '0;
            right_mag  = '0;
            want_right = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_AVERAGING_ON: averaging   = val[0];
                REG_SAMPLE_RATE:  sample_rate = val[SR_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [MAG_W-1:0] root64(longint unsigned x);
            longint unsigned r;
            longint unsigned t;
            r = 0;
            for (int i = ROOT_W - 1; i >= 0; i--) begin
                t = r | (64'd1 << i);
                if (t * t <= x) r = t;
            end
            return r[MAG_W-1:0];
        endfunction

        // one accepted bin -> one expected result
        function void note_bin(logic [IN_W-1:0] re, logic [IN_W-1:0] im);
            longint unsigned ar, ai, pos, dd, ad, off, fq;
            longint          d, a, b, c, den, diff;
            logic [MAG_W-1:0] mag, stored, sv;
            int unsigned     idx;
            bin_result_t     r;

            ar = re[IN_W-1] ? (64'd4294967296 - {32'd0, re}) : {32'd0, re};
            ai = im[IN_W-1] ? (64'd4294967296 - {32'd0, im}) : {32'd0, im};
            mag = root64(ar * ar + ai * ai);
            idx = next_bin;

            stored = avg_mem[idx];
            if (averaging) begin
                d  = longint'(mag) - longint'(stored);
                sv = MAG_W'(longint'(stored) + (d >>> 2));
            end else begin
                sv = mag;
            end
            avg_mem[idx] = sv;

            if (want_right) begin
                right_mag  = sv;
                want_right = 1'b0;
            end
            if (sv > best_mag) begin
                best_mag   = sv;
                best_index = idx;
                left_mag   = prev_mag;
                want_right = 1'b1;
            end
            prev_mag = sv;

            r = '{default: '0};
            r.bin_index     = idx[IDX_OUT_W-1:0];
            r.raw_magnitude = mag;
            r.avg_magnitude = sv;

            if (idx == LAST_BIN) begin
                pos = longint'(best_index) << FRACTION_BITS;
                if (best_index > 1 && best_index < LAST_BIN) begin
                    a    = longint'(left_mag);
                    b    = longint'(best_mag);
                    c    = longint'(right_mag);
                    den  = 2 * b - a - c;
                    diff = a - c;
                    dd   = (den < 0) ? -den : den;
                    if (dd != 0) begin
                        ad  = (diff < 0) ? -diff : diff;
                        // rounds half away from zero
                        off = ((ad << FRACTION_BITS) + dd) / (2 * dd);
                        if ((diff > 0) == (den > 0))
                            pos = (off > pos) ? 0 : pos - off;
                        else
                            pos = pos + off;
                    end
                end
                fq = (pos * sample_rate * 16 +
                      (longint'(TRANSFORM_POINTS) << (FRACTION_BITS - 1))) /
                     (longint'(TRANSFORM_POINTS) << FRACTION_BITS);
                if (fq > longint'(FQ_MAX)) fq = FQ_MAX;
                r.frame_done     = 1'b1;
                r.peak_bin       = best_index[IDX_OUT_W-1:0];
                r.peak_position  = pos[POS_OUT_W-1:0];
                r.peak_freq_q4   = fq[FQ_W-1:0];
                r.peak_magnitude = best_mag;
                clear_track();
            end else begin
                next_bin = idx + 1;
            end
            pending.insert(pending.size(), r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) $display("ERROR at result %0d: %s", checked, msg);
        endtask

        task match(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task check_result(logic [M_TDATA_W-1:0] data, logic tlast_in);
            bin_result_t e;
            if (pending.size() == 0) begin
                report("result transfer with no bin outstanding");
                checked++;
                return;
            end
            e = pending.pop_front();
            match("bin_index", data[0 +: IDX_OUT_W], e.bin_index);
            match("raw_magnitude", data[RAW_LSB +: MAG_W], e.raw_magnitude);
            match("avg_magnitude", data[AVG_LSB +: MAG_W], e.avg_magnitude);
            match("frame_done", tlast_in, e.frame_done);
            match("peak_bin", data[PKB_LSB +: IDX_OUT_W], e.peak_bin);
            match("peak_position", data[POS_LSB +: POS_OUT_W], e.peak_position);
            match("peak_freq_q4", data[FQ_LSB +: FQ_W], e.peak_freq_q4);
            match("peak_magnitude", data[PKM_LSB +: MAG_W], e.peak_magnitude);
            match("zero fill", data[M_TDATA_W-1:FILL_LSB], '0);
            checked++;
        endtask
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = REG_AVERAGING_ON;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    spectrum_scoreboard sb;
    bit                 idle_on     = 1'b1;
    int unsigned        cycle_count = 0;

    spectrum_average_peak_tracker DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [IN_W-1:0] random_part();
        logic [IN_W-1:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1, 2: return 32'($urandom_range(0, 510)) - 32'd255;
            3, 4, 5: return {{16{r[15]}}, r[15:0]};
            default: return r;
        endcase
    endfunction

    task automatic make_bin(frame_kind_t kind, int bin, int planted,
                            output logic [IN_W-1:0] re, output logic [IN_W-1:0] im);
        re = random_part();
        im = random_part();
        case (kind)
            FRAME_EXTREMES: begin
                case (bin)
                    1:  begin re = 32'h8000_0000; im = 32'h8000_0000; end
                    2:  begin re = 32'h7FFF_FFFF; im = 32'h7FFF_FFFF; end
                    3:  begin re = 32'h0000_0000; im = 32'h0000_0000; end
                    4:  begin re = 32'hFFFF_FFFF; im = 32'hFFFF_FFFF; end
                    5:  begin re = 32'h7FFF_FFFF; im = 32'h8000_0000; end
                    6:  begin re = 32'h8000_0000; im = 32'h0000_0000; end
                    7:  begin re = 32'h0000_0000; im = 32'h7FFF_FFFF; end
                    8:  begin re = 32'h0000_0001; im = 32'h0000_0000; end
                    9:  begin re = 32'h0000_0003; im = 32'hFFFF_FFFC; end
                    10: begin re = 32'h5555_5555; im = 32'hAAAA_AAAA; end
                    11: begin re = 32'hAAAA_AAAA; im = 32'h5555_5555; end
                    12: begin re = 32'hFFFF_0000; im = 32'h0000_FFFF; end
                    13: begin re = 32'h0001_0000; im = 32'h0000_0000; end
                    default: ;
                endcase
            end
            FRAME_TAIL_PEAK: begin
                // the largest input pair, both parts at 32'h8000_0000, appears only on the last bin
                if (bin == LAST_BIN) begin
                    re = 32'h8000_0000;
                    im = 32'h8000_0000;
                end else if (re == 32'h8000_0000 && im == 32'h8000_0000) begin
                    im = 32'h7FFF_FFFF;
                end
            end
            FRAME_SILENT: begin
                re = '0;
                im = '0;
            end
            FRAME_TIE: begin
                // stored is zero here and averaging on, so stored = mag / 4;
                // neighbors 999745 / 999743 around 1000000 give an offset of exactly half an LSB, 1/512 bin
                im = '0;
                if (bin == planted - 1)      re = 32'd3998980;
                else if (bin == planted)     re = -32'd4000000;
                else if (bin == planted + 1) re = 32'd3998972;
                else begin
                    re = 32'($urandom_range(0, 4000)) - 32'd2000;
                    im = 32'($urandom_range(0, 4000)) - 32'd2000;
                end
            end
            default: ;
        endcase
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(negedge aclk);
    endtask

    task automatic send_bin(logic [IN_W-1:0] re, logic [IN_W-1:0] im);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {im, re};
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_bin(re, im);
        @(negedge aclk);
    endtask

    task automatic run_frame(frame_kind_t kind, logic [CFG_DATA_W-1:0] avg_word,
                             logic [CFG_DATA_W-1:0] rate);
        logic [IN_W-1:0] re, im;
        int              planted;
        wait_drained();
        write_reg(REG_AVERAGING_ON, avg_word);
        write_reg(REG_SAMPLE_RATE, rate);
        planted = $urandom_range(10, 4000);
        for (int bin = 1; bin <= LAST_BIN; bin++) begin
            if (bin % 256 == 1) idle_on = ($urandom_range(0, 3) != 0);
            make_bin(kind, bin, planted, re, im);
            send_bin(re, im);
        end
        s_tvalid = 1'b0;
    endtask

    // result side: random stalls, plus two long hold-offs that back the block up
    initial begin
        int hold;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            hold = idle_on ? $urandom_range(0, 6) : 0;
            if (sb.checked == 600 || sb.checked == 9000) hold = LONG_HOLD;
            if (hold > 0) begin
                m_tready = 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            sb.check_result(m_tdata, m_tlast);
            @(negedge aclk);
        end
    end

    initial begin
        sb = new();
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // bit 0 of the averaging word is all that counts
        run_frame(FRAME_EXTREMES, 18'h3FFFE, 18'd192000);
        run_frame(FRAME_BLEND, 18'h2AAAB, 18'd1000);
        run_frame(FRAME_TAIL_PEAK, 18'h00000, 18'h3FFFF);
        run_frame(FRAME_SILENT, 18'h00000, 18'h00000);
        run_frame(FRAME_TIE, 18'h00001, 18'($urandom_range(1000, 192000)));

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
